/* src/sstq_pkg.sv */
`default_nettype none
package sstq_pkg;

	localparam int QDEPTH      = 16;
	localparam int ID_BITS     = 8;
	localparam int TICK_W      = 48;
	localparam int DELAY_W     = 32;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(QDEPTH);
	localparam int CNT_W       = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_REPLY,
		S_TICK
	} state_t;

	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic [TICK_W-1:0]   wake;
		logic [ID_BITS-1:0]  id;
	} wr_t;

	// ring position of the entry at a given offset from the head
	function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(QDEPTH))
			s = s - (CNT_W+1)'(QDEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/sstq_cmp.sv */
`default_nettype none
module sstq_cmp
	import sstq_pkg::*;
(
	input  wire logic [TICK_W-1:0] a,
	input  wire logic [TICK_W-1:0] b,
	output logic                   a_lt,
	output logic                   a_eq
);

	assign a_lt = a < b;
	assign a_eq = a == b;

endmodule
`default_nettype wire

/* src/sstq_mem.sv */
`default_nettype none
module sstq_mem
	import sstq_pkg::*;
(
	input  wire logic               clk,
	input  wire wr_t                wr,
	input  wire logic [IDX_W-1:0]   rd_idx,
	output logic [TICK_W-1:0]       rd_wake,
	output logic [ID_BITS-1:0]      rd_id
);

	logic [TICK_W-1:0]  wake_mem [QDEPTH];
	logic [ID_BITS-1:0] id_mem   [QDEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			wake_mem[wr.idx] <= wr.wake;
			id_mem[wr.idx]   <= wr.id;
		end
	end

	always_ff @(posedge clk) begin
		rd_wake <= wake_mem[rd_idx];
		rd_id   <= id_mem[rd_idx];
	end

endmodule
`default_nettype wire

/* src/sorted_sleep_timer_queue_unit.sv */
// Sorted sleep timer queue.
// Input channel req_valid/req_stall carries one word: a tick event (req_type 0)
// or a sleep request (req_type 1, thread_id, sleep_ticks). Output channel
// rsp_valid/rsp_stall carries result words; last marks the final word of
// each input word. A sleep request gives one word with its status; a tick
// gives one word per released thread, or one word with woken_valid low.
// The queue is a ring of QDEPTH entries walked one entry per cycle through a
// single wake-tick comparator, unless a tick waits on the output register.
// A sleep request makes the duplicate and position scan, moves the entries
// behind the new place to make room, writes the new entry and then replies.
// A full queue is rejected without a scan. A tick releases the due threads
// from the head. req_stall is high for the whole time an item is in work, so
// one item is handled at a time.
// A finished word waits in the output register while rsp_stall is high; the
// sequencer holds until it can hand over the next word.
// Reset clears the tick counter and empties the queue; no clearing pass.
`default_nettype none
module sorted_sleep_timer_queue_unit
	import sstq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic                req_type,
	input  wire logic [7:0]          thread_id,
	input  wire logic [DELAY_W-1:0]  sleep_ticks,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic                     woken_valid,
	output logic [7:0]               woken_thread,
	output logic [1:0]               status,
	output logic [TICK_W-1:0]        tick_now,
	output logic                     last
);

	state_t              state_q, state_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [TICK_W-1:0]   ref_q, ref_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]    head_q, head_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic                found_q, found_d;
	logic [ID_BITS-1:0]  id_q, id_d;
	status_t             status_q, status_d;
	logic                pend_v_q, pend_v_d;
	logic [ID_BITS-1:0]  pend_id_q, pend_id_d;

	logic                rsp_valid_q;
	logic                woken_valid_q;
	logic [ID_BITS-1:0]  woken_id_q;
	status_t             rsp_status_q;
	logic [TICK_W-1:0]   tick_now_q;
	logic                last_q;

	logic                push;
	logic                push_ok;
	logic                p_valid;
	logic [ID_BITS-1:0]  p_id;
	status_t             p_status;
	logic                p_last;

	wr_t                 wr;
	logic [CNT_W-1:0]    rd_off;
	logic [TICK_W-1:0]   rd_wake;
	logic [ID_BITS-1:0]  rd_id;
	logic                ent_lt, ent_eq;
	logic [TICK_W:0]     wake_sum;
	logic [TICK_W-1:0]   wake_sat;
	logic                due;

	// read address of the entry needed next cycle
	assign rd_off = (state_d == S_SHIFT) ? idx_d - CNT_W'(1) : idx_d;

	sstq_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_idx  (phys_idx(head_q, rd_off)),
		.rd_wake (rd_wake),
		.rd_id   (rd_id)
	);

	sstq_cmp u_cmp (
		.a    (rd_wake),
		.b    (ref_q),
		.a_lt (ent_lt),
		.a_eq (ent_eq)
	);

	// wake-up tick, saturating at the counter maximum
	assign wake_sum = (TICK_W+1)'(tick_q) + (TICK_W+1)'(sleep_ticks);
	assign wake_sat = wake_sum[TICK_W] ? {TICK_W{1'b1}} : wake_sum[TICK_W-1:0];

	assign push_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign due       = (idx_q < cnt_q) && (int'(idx_q) < MAX_RESULTS) && (ent_lt || ent_eq);

	always_comb begin
		state_d   = state_q;
		tick_d    = tick_q;
		ref_d     = ref_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		found_d   = found_q;
		id_d      = id_q;
		status_d  = status_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		push      = 1'b0;
		p_valid   = 1'b0;
		p_id      = '0;
		p_status  = ST_OK;
		p_last    = 1'b1;
		wr        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					id_d  = thread_id[ID_BITS-1:0];
					idx_d = '0;
					if (req_type) begin
						ref_d   = wake_sat;
						found_d = 1'b0;
						if (cnt_q == CNT_W'(QDEPTH)) begin
							status_d = ST_FULL;
							state_d  = S_REPLY;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						tick_d   = tick_q + TICK_W'(1);
						ref_d    = tick_q + TICK_W'(1);
						pend_v_d = 1'b0;
						state_d  = S_TICK;
					end
				end
			end
			S_SCAN: begin
				if (idx_q == cnt_q) begin
					if (!found_q)
						pos_d = cnt_q;
					state_d = S_SHIFT;
				end else if (rd_id == id_q) begin
					status_d = ST_DUP;
					state_d  = S_REPLY;
				end else begin
					if (!found_q && !ent_lt) begin
						pos_d   = idx_q;
						found_d = 1'b1;
					end
					idx_d = idx_q + CNT_W'(1);
				end
			end
			S_SHIFT: begin
				wr.en = 1'b1;
				if (idx_q > pos_q) begin
					wr.idx  = phys_idx(head_q, idx_q);
					wr.wake = rd_wake;
					wr.id   = rd_id;
					idx_d   = idx_q - CNT_W'(1);
				end else begin
					wr.idx   = phys_idx(head_q, pos_q);
					wr.wake  = ref_q;
					wr.id    = id_q;
					cnt_d    = cnt_q + CNT_W'(1);
					status_d = ST_OK;
					state_d  = S_REPLY;
				end
			end
			S_REPLY: begin
				if (push_ok) begin
					push     = 1'b1;
					p_status = status_q;
					state_d  = S_IDLE;
				end
			end
			S_TICK: begin
				if (due) begin
					if (!pend_v_q || push_ok) begin
						if (pend_v_q) begin
							push    = 1'b1;
							p_valid = 1'b1;
							p_id    = pend_id_q;
							p_last  = 1'b0;
						end
						pend_v_d  = 1'b1;
						pend_id_d = rd_id;
						idx_d     = idx_q + CNT_W'(1);
					end
				end else if (push_ok) begin
					push    = 1'b1;
					p_valid = pend_v_q;
					p_id    = pend_v_q ? pend_id_q : '0;
					head_d  = phys_idx(head_q, idx_q);
					cnt_d   = cnt_q - idx_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			tick_q   <= tick_d;
			cnt_q    <= cnt_d;
			head_q   <= head_d;
			pend_v_q <= pend_v_d;
			if (push)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ref_q     <= ref_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		found_q   <= found_d;
		id_q      <= id_d;
		status_q  <= status_d;
		pend_id_q <= pend_id_d;
		if (push) begin
			woken_valid_q <= p_valid;
			woken_id_q    <= p_id;
			rsp_status_q  <= p_status;
			tick_now_q    <= tick_q;
			last_q        <= p_last;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign woken_valid  = woken_valid_q;
	assign woken_thread = 8'(woken_id_q);
	assign status       = rsp_status_q;
	assign tick_now     = tick_now_q;
	assign last         = last_q;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import sstq_pkg::*;

	localparam int NUM_RANDOM = 295;
	localparam int WATCHDOG   = 5000;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN      = 2 * QDEPTH + 8;

	typedef struct packed {
		logic              woken;
		logic [7:0]        thr;
		status_t           st;
		logic [TICK_W-1:0] now;
		logic              fin;
	} reply_t;

	typedef struct packed {
		logic               is_sleep;
		logic [7:0]         tid;
		logic [DELAY_W-1:0] delay;
		logic               typed;
		reply_t             want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               req_type;
	logic [7:0]         thread_id;
	logic [DELAY_W-1:0] sleep_ticks;
	logic               rsp_valid;
	logic               rsp_stall;
	logic               woken_valid;
	logic [7:0]         woken_thread;
	logic [1:0]         status;
	logic [TICK_W-1:0]  tick_now;
	logic               last;

	// timer state as the block should hold it
	logic [TICK_W-1:0] mdl_now = '0;
	logic [TICK_W-1:0] mdl_wake [QDEPTH];
	logic [7:0]        mdl_tid [QDEPTH];
	int                mdl_len = 0;

	reply_t    owed_replies[$];
	plan_row_t plan[$];
	reply_t    head_reply;

	int n_errors   = 0;
	int n_sent     = 0;
	int n_checked  = 0;
	int n_full     = 0;
	int n_dup      = 0;
	int most_woken = 0;
	int idle_run   = 0;
	bit calm       = 1'b0;
	bit hold_req   = 1'b0;

	always #5 clk = ~clk;

	sorted_sleep_timer_queue_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.thread_id    (thread_id),
		.sleep_ticks  (sleep_ticks),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.woken_valid  (woken_valid),
		.woken_thread (woken_thread),
		.status       (status),
		.tick_now     (tick_now),
		.last         (last)
	);

	task automatic report_mismatch(input string what, input logic [TICK_W-1:0] got,
			input logic [TICK_W-1:0] want);
		n_errors++;
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// advances the timer state by one word and queues the replies it owes
	task automatic step_sleep_queue(input logic is_sleep, input logic [7:0] tid_in,
			input logic [DELAY_W-1:0] delay, input bit keep);
		logic [7:0]        tid;
		logic [TICK_W:0]   sum;
		logic [TICK_W-1:0] wake;
		int                pos;
		int                n;
		bit                dup;
		reply_t            r;
		tid = tid_in & 8'((1 << ID_BITS) - 1);
		r.woken = 1'b0;
		r.thr = 8'd0;
		r.st = ST_OK;
		r.fin = 1'b1;
		if (is_sleep) begin
			dup = 1'b0;
			for (int i = 0; i < mdl_len; i++)
				if (mdl_tid[i] == tid)
					dup = 1'b1;
			if (mdl_len >= QDEPTH) begin
				r.st = ST_FULL;
				n_full++;
			end else if (dup) begin
				r.st = ST_DUP;
				n_dup++;
			end else begin
				sum = {1'b0, mdl_now} + (TICK_W+1)'(delay);
				wake = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
				pos = 0;
				while (pos < mdl_len && mdl_wake[pos] < wake)
					pos++;
				for (int i = mdl_len; i > pos; i--) begin
					mdl_wake[i] = mdl_wake[i-1];
					mdl_tid[i] = mdl_tid[i-1];
				end
				mdl_wake[pos] = wake;
				mdl_tid[pos] = tid;
				mdl_len++;
			end
			r.now = mdl_now;
			if (keep)
				owed_replies.push_back(r);
		end else begin
			mdl_now = mdl_now + 1'b1;
			r.now = mdl_now;
			n = 0;
			while (n < mdl_len && n < MAX_RESULTS && mdl_wake[n] <= mdl_now)
				n++;
			if (n > most_woken)
				most_woken = n;
			if (n == 0 && keep)
				owed_replies.push_back(r);
			for (int i = 0; i < n; i++) begin
				r.woken = 1'b1;
				r.thr = mdl_tid[i];
				r.fin = (i == n - 1);
				if (keep)
					owed_replies.push_back(r);
			end
			for (int i = n; i < mdl_len; i++) begin
				mdl_wake[i-n] = mdl_wake[i];
				mdl_tid[i-n] = mdl_tid[i];
			end
			mdl_len -= n;
		end
	endtask

	function automatic plan_row_t row_of(input logic s, input logic [7:0] tid,
			input logic [DELAY_W-1:0] d, input logic typed = 1'b0,
			input status_t st = ST_OK, input logic [TICK_W-1:0] now = '0,
			input logic wk = 1'b0, input logic [7:0] thr = 8'd0);
		plan_row_t r;
		r = '0;
		r.is_sleep = s;
		r.tid = tid;
		r.delay = d;
		r.typed = typed;
		r.want.woken = wk;
		r.want.thr = thr;
		r.want.st = st;
		r.want.now = now;
		r.want.fin = 1'b1;
		return r;
	endfunction

	task automatic offer_word(input plan_row_t row);
		if (!calm && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= row.is_sleep;
		thread_id <= row.tid;
		sleep_ticks <= row.delay;
		do @(posedge clk); while (req_stall !== 1'b0);
		n_sent++;
		step_sleep_queue(row.is_sleep, row.tid, row.delay, !row.typed);
		if (row.typed)
			owed_replies.push_back(row.want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_replies.size() == 0) begin
				report_mismatch("word with nothing owed", tick_now, '0);
			end else begin
				head_reply = owed_replies.pop_front();
				n_checked++;
				if (woken_valid !== head_reply.woken)
					report_mismatch("woken_valid", TICK_W'(woken_valid),
						TICK_W'(head_reply.woken));
				if (woken_thread !== head_reply.thr)
					report_mismatch("woken_thread", TICK_W'(woken_thread),
						TICK_W'(head_reply.thr));
				if (status !== head_reply.st)
					report_mismatch("status", TICK_W'(status), TICK_W'(head_reply.st));
				if (tick_now !== head_reply.now)
					report_mismatch("tick_now", tick_now, head_reply.now);
				if (last !== head_reply.fin)
					report_mismatch("last", TICK_W'(last), TICK_W'(head_reply.fin));
			end
		end
	end

	// receiver side
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 14);
			end
		end
	end

	initial begin
		while (idle_run < WATCHDOG) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("no word moved for %0d cycles, %0d replies still owed", WATCHDOG,
			owed_replies.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		plan_row_t row;
		int        burst_left;
		int        mode;
		int        flood_delay;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_type <= 1'b0;
		thread_id <= 8'd0;
		sleep_ticks <= '0;
		burst_left = 0;
		mode = 0;
		flood_delay = 0;

		plan.push_back(row_of(1'b0, 8'd0, 32'd0, 1'b1, ST_OK, 48'd1));
		plan.push_back(row_of(1'b1, 8'd0, 32'd0, 1'b1, ST_OK, 48'd1));
		plan.push_back(row_of(1'b1, 8'd255, '1, 1'b1, ST_OK, 48'd1));
		plan.push_back(row_of(1'b1, 8'd0, 32'd7, 1'b1, ST_DUP, 48'd1));
		plan.push_back(row_of(1'b0, 8'd0, 32'd0, 1'b1, ST_OK, 48'd2, 1'b1, 8'd0));
		// equal wake ticks leave newest first
		plan.push_back(row_of(1'b1, 8'd10, 32'd3));
		plan.push_back(row_of(1'b1, 8'd11, 32'd3));
		plan.push_back(row_of(1'b1, 8'd12, 32'd1));
		plan.push_back(row_of(1'b1, 8'd13, 32'd2));
		for (int k = 20; k <= 30; k++)
			plan.push_back(row_of(1'b1, 8'(k), 32'd3));
		// full wins over duplicate
		plan.push_back(row_of(1'b1, 8'd99, 32'd1, 1'b1, ST_FULL, 48'd2));
		plan.push_back(row_of(1'b1, 8'd10, 32'd1, 1'b1, ST_FULL, 48'd2));
		repeat (3) plan.push_back(row_of(1'b0, 8'd0, 32'd0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			offer_word(plan[k]);

		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (k == 60)
				calm = 1'b1;
			if (k == 130)
				calm = 1'b0;
			if (k == 170)
				hold_req = 1'b1;
			if (k == 250) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (owed_replies.size() != 0) @(posedge clk);
			end
			if (burst_left == 0) begin
				mode = $urandom_range(0, 2);
				burst_left = $urandom_range(6, 16);
				flood_delay = $urandom_range(0, 5);
			end
			burst_left--;
			row = '0;
			row.tid = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 31))
				: 8'($urandom_range(0, 255));
			row.delay = ($urandom_range(39) == 0) ? DELAY_W'($urandom)
				: DELAY_W'($urandom_range(0, 15));
			case (mode)
				0: row.is_sleep = 1'($urandom_range(1));
				1: begin
					row.is_sleep = $urandom_range(99) < 75;
					if (row.is_sleep)
						row.delay = DELAY_W'(flood_delay);
				end
				default: row.is_sleep = $urandom_range(99) < 15;
			endcase
			offer_word(row);
		end
		req_valid <= 1'b0;

		while (owed_replies.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("%0d words sent (%0d directed), %0d result words checked", n_sent,
			plan.size(), n_checked);
		$display("%0d full rejects, %0d duplicate rejects, up to %0d threads woken by one tick",
			n_full, n_dup, most_woken);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
